/* rtl/lpc_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Lift position controller package
// Shared widths, configuration record, register map and reset values.
// ----------------------------------------------------------------------------
package lpc_pkg;

  localparam int SPEED_W  = 16;
  localparam int COUNT_W  = 32;
  localparam int DRIVE_W  = 16;
  localparam int TARGET_W = 32;
  localparam int DELTA_W  = 18;
  localparam int ERR_W    = 41;
  localparam int MAG_W    = 40;
  localparam int MUL_W    = 24;
  localparam int ADDR_W   = 5;
  localparam int DATA_W   = 32;

  localparam logic [15:0] MAX_SETPOINT_RST = 16'd2400;
  localparam logic [7:0]  STEP_RST         = 8'd17;
  localparam logic [15:0] SOFT_ZONE_RST    = 16'd400;
  localparam logic [15:0] GAIN_SOFT_RST    = 16'd197;
  localparam logic [15:0] GAIN_NORMAL_RST  = 16'd393;
  localparam logic [9:0]  DEAD_ZONE_RST    = 10'd10;

  localparam logic [DRIVE_W-2:0] DRIVE_MAX = 15'h7fff;

  typedef enum logic [2:0] {
    REG_MAX_SETPOINT = 3'd0,
    REG_STEP         = 3'd1,
    REG_SOFT_ZONE    = 3'd2,
    REG_GAIN_SOFT    = 3'd3,
    REG_GAIN_NORMAL  = 3'd4,
    REG_DEAD_ZONE    = 3'd5
  } reg_idx_t;

  typedef struct packed {
    logic [15:0] max_setpoint;
    logic [7:0]  step_per_speed;
    logic [15:0] soft_zone;
    logic [15:0] gain_soft;
    logic [15:0] gain_normal;
    logic [9:0]  dead_zone;
  } cfg_t;

endpackage

/* rtl/lpc_cfg_regs.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Lift position controller configuration registers
// APB-style register file holding the controller settings.
// ----------------------------------------------------------------------------
module lpc_cfg_regs
  import lpc_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg
);

  cfg_t     cfg_r;
  cfg_t     cfg_nxt;
  reg_idx_t idx;
  logic     wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);
  assign cfg    = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (idx)
        REG_MAX_SETPOINT: cfg_nxt.max_setpoint   = pwdata[15:0];
        REG_STEP:         cfg_nxt.step_per_speed = pwdata[7:0];
        REG_SOFT_ZONE:    cfg_nxt.soft_zone      = pwdata[15:0];
        REG_GAIN_SOFT:    cfg_nxt.gain_soft      = pwdata[15:0];
        REG_GAIN_NORMAL:  cfg_nxt.gain_normal    = pwdata[15:0];
        REG_DEAD_ZONE:    cfg_nxt.dead_zone      = pwdata[9:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_MAX_SETPOINT: prdata = {16'd0, cfg_r.max_setpoint};
      REG_STEP:         prdata = {24'd0, cfg_r.step_per_speed};
      REG_SOFT_ZONE:    prdata = {16'd0, cfg_r.soft_zone};
      REG_GAIN_SOFT:    prdata = {16'd0, cfg_r.gain_soft};
      REG_GAIN_NORMAL:  prdata = {16'd0, cfg_r.gain_normal};
      REG_DEAD_ZONE:    prdata = {22'd0, cfg_r.dead_zone};
      default:          prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.max_setpoint   <= MAX_SETPOINT_RST;
      cfg_r.step_per_speed <= STEP_RST;
      cfg_r.soft_zone      <= SOFT_ZONE_RST;
      cfg_r.gain_soft      <= GAIN_SOFT_RST;
      cfg_r.gain_normal    <= GAIN_NORMAL_RST;
      cfg_r.dead_zone      <= DEAD_ZONE_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

/* rtl/lpc_target_step.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Lift position controller setpoint step
// Adds the per-tick step to a setpoint and clamps it to the allowed range.
// ----------------------------------------------------------------------------
module lpc_target_step
  import lpc_pkg::*;
(
  input  logic signed [TARGET_W-1:0] target,
  input  logic signed [DELTA_W-1:0]  delta,
  input  logic        [15:0]         max_setpoint,
  output logic signed [TARGET_W-1:0] target_new
);

  logic signed [TARGET_W+1:0] sum;
  logic signed [TARGET_W+1:0] hi;
  logic signed [TARGET_W+1:0] lo;
  logic signed [TARGET_W+1:0] clamped;

  assign sum = {{2{target[TARGET_W-1]}}, target}
             + {{(TARGET_W+2-DELTA_W){delta[DELTA_W-1]}}, delta};
  assign hi  = $signed({{(TARGET_W-22){1'b0}}, max_setpoint, 8'd0});
  assign lo  = $signed({3'b111, {(TARGET_W-1){1'b0}}});

  always_comb begin
    if (sum > hi) begin
      clamped = hi;
    end else if (sum < lo) begin
      clamped = lo;
    end else begin
      clamped = sum;
    end
  end

  assign target_new = clamped[TARGET_W-1:0];

endmodule

/* rtl/lpc_axis_law.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Lift position controller proportional law
// Error, dead zone, gain multiply and Q1.15 saturation for one side.
// The drive carries the sign of the error.
// ----------------------------------------------------------------------------
module lpc_axis_law
  import lpc_pkg::*;
(
  input  logic signed [COUNT_W-1:0]  pos,
  input  logic signed [TARGET_W-1:0] target,
  input  logic        [15:0]         gain,
  input  logic        [9:0]          dead_zone,
  output logic signed [DRIVE_W-1:0]  drive
);

  logic signed [ERR_W-1:0]   err;
  logic        [ERR_W-1:0]   err_abs;
  logic        [MAG_W-1:0]   mag;
  logic        [MAG_W-1:0]   dz;
  logic        [MAG_W-1:0]   prod;
  logic        [DRIVE_W-2:0] d;
  logic        [DRIVE_W-1:0] d_ext;

  assign err     = {{(ERR_W-COUNT_W-8){pos[COUNT_W-1]}}, pos, 8'd0}
                 - {{(ERR_W-TARGET_W){target[TARGET_W-1]}}, target};
  assign err_abs = err[ERR_W-1] ? (-err) : err;
  assign mag     = err_abs[MAG_W-1:0];
  assign dz      = {{(MAG_W-18){1'b0}}, dead_zone, 8'd0};
  assign prod    = {{(MAG_W-MUL_W){1'b0}}, mag[MUL_W-1:0]} * {{(MAG_W-16){1'b0}}, gain};

  always_comb begin
    if (mag < dz || mag == '0) begin
      d = '0;
    end else if (|mag[MAG_W-1:MUL_W]) begin
      d = (gain == '0) ? '0 : DRIVE_MAX;
    end else if (|prod[MAG_W-1:MUL_W]) begin
      d = DRIVE_MAX;
    end else begin
      d = prod[MUL_W-1:9];
    end
  end

  assign d_ext = {1'b0, d};
  assign drive = err[ERR_W-1] ? $signed(-d_ext) : $signed(d_ext);

endmodule

/* rtl/dual_axis_lift_position_controller.sv */
`timescale 1ns / 1ps
// A beat passes the input register, then the output register. Throughput:
// one beat per cycle unless the output stalls; the speed step product is
// registered; setpoints, gain choice, drives and homing are combinational.
// A stalled output holds its beat while one more input beat is buffered.
// Reset: settings return to their defaults; setpoints, home offsets and
// previous drives clear to zero.
// ----------------------------------------------------------------------------
// Dual-axis lift position controller
// Proportional position control of two lift sides with soft landing and
// homing on the bottom limit switches.
// ----------------------------------------------------------------------------
module dual_axis_lift_position_controller
  import lpc_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  // speed[15:0], raw_count_left[47:16], raw_count_right[79:48]
  input  logic [79:0]       in_tdata,
  // limit_left[0], limit_right[1]
  input  logic [1:0]        in_tuser,
  input  logic              in_tvalid,
  output logic              in_tready,
  // drive_left[15:0], drive_right[31:16], position_left[63:32],
  // position_right[95:64]
  output logic [95:0]       out_tdata,
  output logic              out_tvalid,
  input  logic              out_tready,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [ADDR_W-1:0] cfg_paddr,
  input  logic [DATA_W-1:0] cfg_pwdata,
  output logic [DATA_W-1:0] cfg_prdata,
  output logic              cfg_pready
);

  cfg_t cfg;

  lpc_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  // Input stage.
  logic signed [24:0] spd_x;
  logic signed [24:0] stp_x;
  logic signed [24:0] sp_prod;
  logic signed [24:0] sp_num;
  logic signed [DELTA_W-1:0] delta_in;
  logic in_fire;
  logic advance;

  logic                      s0_valid_r;
  logic signed [DELTA_W-1:0] s0_delta_r;
  logic signed [COUNT_W-1:0] s0_raw_left_r;
  logic signed [COUNT_W-1:0] s0_raw_right_r;
  logic                      s0_lim_left_r;
  logic                      s0_lim_right_r;

  assign spd_x    = {{(25-SPEED_W){in_tdata[SPEED_W-1]}}, in_tdata[SPEED_W-1:0]};
  assign stp_x    = $signed({17'd0, cfg.step_per_speed});
  assign sp_prod  = spd_x * stp_x;
  assign sp_num   = 25'sd64 - sp_prod;
  assign delta_in = sp_num[24:7];

  assign in_tready = !s0_valid_r || !out_tvalid || out_tready;
  assign in_fire   = in_tvalid && in_tready;
  assign advance   = s0_valid_r && (!out_tvalid || out_tready);

  // Control stage state.
  logic signed [TARGET_W-1:0] target_left_r;
  logic signed [TARGET_W-1:0] target_right_r;
  logic signed [COUNT_W-1:0]  home_left_r;
  logic signed [COUNT_W-1:0]  home_right_r;
  logic signed [DRIVE_W-1:0]  last_left_r;
  logic signed [DRIVE_W-1:0]  last_right_r;

  logic signed [TARGET_W-1:0] tgt_left_step;
  logic signed [TARGET_W-1:0] tgt_right_step;
  logic signed [COUNT_W-1:0]  pos_left;
  logic signed [COUNT_W-1:0]  pos_right;
  logic                       soft_sel;
  logic        [15:0]         gain;
  logic signed [DRIVE_W-1:0]  law_left;
  logic signed [DRIVE_W-1:0]  law_right;
  logic                       home_left;
  logic                       home_right;

  logic signed [TARGET_W-1:0] target_left_nxt;
  logic signed [TARGET_W-1:0] target_right_nxt;
  logic signed [COUNT_W-1:0]  home_left_nxt;
  logic signed [COUNT_W-1:0]  home_right_nxt;
  logic signed [DRIVE_W-1:0]  drive_left_nxt;
  logic signed [DRIVE_W-1:0]  drive_right_nxt;
  logic signed [COUNT_W-1:0]  pos_left_nxt;
  logic signed [COUNT_W-1:0]  pos_right_nxt;

  lpc_target_step u_step_left (
    .target       (target_left_r),
    .delta        (s0_delta_r),
    .max_setpoint (cfg.max_setpoint),
    .target_new   (tgt_left_step)
  );

  lpc_target_step u_step_right (
    .target       (target_right_r),
    .delta        (s0_delta_r),
    .max_setpoint (cfg.max_setpoint),
    .target_new   (tgt_right_step)
  );

  assign pos_left  = s0_raw_left_r - home_left_r;
  assign pos_right = s0_raw_right_r - home_right_r;

  assign soft_sel = (($signed({pos_left[COUNT_W-1], pos_left})
                       < $signed({17'd0, cfg.soft_zone}))
                      && last_left_r[DRIVE_W-1])
                 || (($signed({pos_right[COUNT_W-1], pos_right})
                       < $signed({17'd0, cfg.soft_zone}))
                      && !last_right_r[DRIVE_W-1] && (last_right_r != '0));
  assign gain = soft_sel ? cfg.gain_soft : cfg.gain_normal;

  lpc_axis_law u_law_left (
    .pos       (pos_left),
    .target    (tgt_left_step),
    .gain      (gain),
    .dead_zone (cfg.dead_zone),
    .drive     (law_left)
  );

  lpc_axis_law u_law_right (
    .pos       (pos_right),
    .target    (tgt_right_step),
    .gain      (gain),
    .dead_zone (cfg.dead_zone),
    .drive     (law_right)
  );

  // The left drive is mirrored, so it points down when the law is positive.
  assign home_left  = s0_lim_left_r && !law_left[DRIVE_W-1] && (law_left != '0);
  assign home_right = s0_lim_right_r && !law_right[DRIVE_W-1] && (law_right != '0);

  assign target_left_nxt  = home_left ? '0 : tgt_left_step;
  assign target_right_nxt = home_right ? '0 : tgt_right_step;
  assign home_left_nxt    = home_left ? s0_raw_left_r : home_left_r;
  assign home_right_nxt   = home_right ? s0_raw_right_r : home_right_r;
  assign drive_left_nxt   = home_left ? '0 : (-law_left);
  assign drive_right_nxt  = home_right ? '0 : law_right;
  assign pos_left_nxt     = home_left ? '0 : pos_left;
  assign pos_right_nxt    = home_right ? '0 : pos_right;

  logic                      out_valid_r;
  logic signed [DRIVE_W-1:0] out_drive_left_r;
  logic signed [DRIVE_W-1:0] out_drive_right_r;
  logic signed [COUNT_W-1:0] out_pos_left_r;
  logic signed [COUNT_W-1:0] out_pos_right_r;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_pos_right_r, out_pos_left_r, out_drive_right_r, out_drive_left_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r     <= 1'b0;
      out_valid_r    <= 1'b0;
      target_left_r  <= '0;
      target_right_r <= '0;
      home_left_r    <= '0;
      home_right_r   <= '0;
      last_left_r    <= '0;
      last_right_r   <= '0;
    end else begin
      if (in_fire) begin
        s0_valid_r <= 1'b1;
      end else if (advance) begin
        s0_valid_r <= 1'b0;
      end
      if (advance) begin
        out_valid_r    <= 1'b1;
        target_left_r  <= target_left_nxt;
        target_right_r <= target_right_nxt;
        home_left_r    <= home_left_nxt;
        home_right_r   <= home_right_nxt;
        last_left_r    <= drive_left_nxt;
        last_right_r   <= drive_right_nxt;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s0_delta_r     <= delta_in;
      s0_raw_left_r  <= in_tdata[47:16];
      s0_raw_right_r <= in_tdata[79:48];
      s0_lim_left_r  <= in_tuser[0];
      s0_lim_right_r <= in_tuser[1];
    end
    if (advance) begin
      out_drive_left_r  <= drive_left_nxt;
      out_drive_right_r <= drive_right_nxt;
      out_pos_left_r    <= pos_left_nxt;
      out_pos_right_r   <= pos_right_nxt;
    end
  end

endmodule

/* tb/sv/dual_axis_lift_position_controller_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Dual-axis lift position controller testbench
// Sends control ticks through the input stream and predicts each result beat
// with a behavioral model of setpoints, gain choice, drives and homing. Every
// result beat is checked field by field. Register settings change only while
// the block is idle. Random idling appears on both sides, and long receiver
// holds back the pipeline up to the input. A steady descent at full step ends
// in a landing on both limit switches.
// ----------------------------------------------------------------------------
module dual_axis_lift_position_controller_tb;
  import lpc_pkg::*;

  typedef struct packed {
    logic        lim_r;
    logic        lim_l;
    logic [31:0] raw_r;
    logic [31:0] raw_l;
    logic [15:0] speed;
  } lift_cmd_t;

  typedef struct packed {
    logic [31:0] pos_r;
    logic [31:0] pos_l;
    logic [15:0] drv_r;
    logic [15:0] drv_l;
  } lift_result_t;

  localparam longint TARGET_FLOOR = -64'sd2147483648;
  localparam logic [ADDR_W-1:0] SPARE_ADDR_A = 5'd24;
  localparam logic [ADDR_W-1:0] SPARE_ADDR_B = 5'd28;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic [79:0]       in_tdata = '0;
  logic [1:0]        in_tuser = '0;
  logic              in_tvalid = 1'b0;
  logic              in_tready;
  logic [95:0]       out_tdata;
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  logic              cfg_psel = 1'b0;
  logic              cfg_penable = 1'b0;
  logic              cfg_pwrite = 1'b0;
  logic [ADDR_W-1:0] cfg_paddr = '0;
  logic [DATA_W-1:0] cfg_pwdata = '0;
  logic [DATA_W-1:0] cfg_prdata;
  logic              cfg_pready;

  dual_axis_lift_position_controller dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .out_tdata   (out_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always #1 clk = ~clk;

  // Model state and settings.
  cfg_t        lift_cfg = '{MAX_SETPOINT_RST, STEP_RST, SOFT_ZONE_RST,
                            GAIN_SOFT_RST, GAIN_NORMAL_RST, DEAD_ZONE_RST};
  longint      target_l = 0;
  longint      target_r = 0;
  logic [31:0] home_l = '0;
  logic [31:0] home_r = '0;
  longint      prev_drv_l = 0;
  longint      prev_drv_r = 0;

  lift_cmd_t    cmd_q[$];
  lift_result_t result_q[$];
  lift_cmd_t    cur_cmd;
  bit           calm = 1'b0;
  int           n_queued = 0;
  int           n_in = 0;
  int           n_out = 0;
  int           n_err = 0;
  int           n_home = 0;
  int           n_soft = 0;
  int           n_settings = 0;
  int           hold_left = 0;
  int           hold_at = 400;

  function automatic longint clamp_target(longint t, longint delta);
    longint n;
    longint hi;
    n = t + delta;
    hi = longint'(lift_cfg.max_setpoint) * 256;
    if (n > hi) n = hi;
    if (n < TARGET_FLOOR) n = TARGET_FLOOR;
    return n;
  endfunction

  // Drive with the sign of the error, as the right side uses it.
  function automatic longint prop_drive(longint pos, longint tgt, logic [15:0] gain);
    longint          err;
    longint unsigned mag;
    longint unsigned d;
    err = pos * 256 - tgt;
    mag = (err < 0) ? -err : err;
    if (mag < longint'(lift_cfg.dead_zone) * 256 || mag == 0) return 0;
    d = (mag * gain) >> 9;
    if (d > 32767) d = 32767;
    return (err < 0) ? -longint'(d) : longint'(d);
  endfunction

  function automatic lift_result_t advance_lift(lift_cmd_t c);
    lift_result_t r;
    longint       delta;
    longint       pos_l;
    longint       pos_r;
    longint       drv_l;
    longint       drv_r;
    logic [15:0]  gain;
    bit           soft_sel;
    delta = (64 - longint'(signed'(c.speed)) * longint'(lift_cfg.step_per_speed)) >>> 7;
    target_l = clamp_target(target_l, delta);
    target_r = clamp_target(target_r, delta);
    pos_l = longint'(signed'(c.raw_l - home_l));
    pos_r = longint'(signed'(c.raw_r - home_r));
    soft_sel = (pos_l < longint'(lift_cfg.soft_zone) && prev_drv_l < 0) ||
               (pos_r < longint'(lift_cfg.soft_zone) && prev_drv_r > 0);
    if (soft_sel) n_soft++;
    gain = soft_sel ? lift_cfg.gain_soft : lift_cfg.gain_normal;
    drv_l = -prop_drive(pos_l, target_l, gain);
    drv_r = prop_drive(pos_r, target_r, gain);
    if (c.lim_l && drv_l < 0) begin
      drv_l = 0;
      home_l = c.raw_l;
      target_l = 0;
      pos_l = 0;
      n_home++;
    end
    if (c.lim_r && drv_r > 0) begin
      drv_r = 0;
      home_r = c.raw_r;
      target_r = 0;
      pos_r = 0;
      n_home++;
    end
    prev_drv_l = drv_l;
    prev_drv_r = drv_r;
    r.drv_l = drv_l[15:0];
    r.drv_r = drv_r[15:0];
    r.pos_l = pos_l[31:0];
    r.pos_r = pos_r[31:0];
    return r;
  endfunction

  // Input driver.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        result_q.push_back(advance_lift(cur_cmd));
        n_in++;
      end
      if (!in_tvalid || in_tready) begin
        if (cmd_q.size() != 0 && (calm || $urandom_range(99) >= 14)) begin
          cur_cmd = cmd_q.pop_front();
          in_tdata <= {cur_cmd.raw_r, cur_cmd.raw_l, cur_cmd.speed};
          in_tuser <= {cur_cmd.lim_r, cur_cmd.lim_l};
          in_tvalid <= 1'b1;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  task automatic note_mismatch(string field, logic [31:0] want, logic [31:0] got);
    if (n_err < 40)
      $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
    n_err++;
  endtask

  // Result monitor and receiver stalls.
  always @(posedge clk) begin
    lift_result_t got;
    lift_result_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        got = out_tdata;
        n_out++;
        if (result_q.size() == 0) begin
          note_mismatch("unexpected beat", '0, got.pos_l);
        end else begin
          want = result_q.pop_front();
          if (got.drv_l !== want.drv_l) note_mismatch("drive_left", want.drv_l, got.drv_l);
          if (got.drv_r !== want.drv_r) note_mismatch("drive_right", want.drv_r, got.drv_r);
          if (got.pos_l !== want.pos_l) note_mismatch("position_left", want.pos_l, got.pos_l);
          if (got.pos_r !== want.pos_r)
            note_mismatch("position_right", want.pos_r, got.pos_r);
        end
      end
      if (hold_left != 0) begin
        hold_left--;
      end else if (n_out >= hold_at) begin
        hold_left = 150;
        hold_at = n_out + 8000;
      end
      out_tready <= (hold_left == 0) && (calm || $urandom_range(99) >= 14);
    end
  end

  task automatic push_cmd(logic [15:0] spd, logic [31:0] rl, logic [31:0] rr,
                          logic ll, logic lr);
    cmd_q.push_back('{lr, ll, rr, rl, spd});
    n_queued++;
  endtask

  task automatic wait_idle();
    while (n_in != n_queued || result_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [ADDR_W-1:0] addr, logic [DATA_W-1:0] val);
    @(posedge clk);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= addr;
    cfg_pwdata <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    case (addr[4:2])
      REG_MAX_SETPOINT: lift_cfg.max_setpoint = val[15:0];
      REG_STEP:         lift_cfg.step_per_speed = val[7:0];
      REG_SOFT_ZONE:    lift_cfg.soft_zone = val[15:0];
      REG_GAIN_SOFT:    lift_cfg.gain_soft = val[15:0];
      REG_GAIN_NORMAL:  lift_cfg.gain_normal = val[15:0];
      REG_DEAD_ZONE:    lift_cfg.dead_zone = val[9:0];
      default: ;
    endcase
  endtask

  function automatic logic [ADDR_W-1:0] reg_addr(reg_idx_t r);
    return {r, 2'b00};
  endfunction

  task automatic apply_settings(cfg_t c);
    logic [31:0] junk;
    junk = $urandom;
    wait_idle();
    write_reg(reg_addr(REG_MAX_SETPOINT), {junk[31:16], c.max_setpoint});
    write_reg(reg_addr(REG_STEP), {junk[31:8], c.step_per_speed});
    write_reg(reg_addr(REG_SOFT_ZONE), {junk[31:16], c.soft_zone});
    write_reg(reg_addr(REG_GAIN_SOFT), {junk[15:0], c.gain_soft});
    write_reg(reg_addr(REG_GAIN_NORMAL), {junk[15:0], c.gain_normal});
    write_reg(reg_addr(REG_DEAD_ZONE), {junk[31:10], c.dead_zone});
    n_settings++;
  endtask

  function automatic cfg_t random_settings();
    cfg_t c;
    c.max_setpoint = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(3000));
    c.step_per_speed = 8'($urandom);
    c.soft_zone = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(1500));
    c.gain_soft = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(2000));
    c.gain_normal = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(2000));
    c.dead_zone = ($urandom_range(3) == 0) ? 10'($urandom) : 10'($urandom_range(30));
    return c;
  endfunction

  // Runs of steady speed with encoder counts wandering near home, plus some
  // full-range noise on the counts.
  task automatic random_phase(int n_ticks);
    int          seg;
    logic [15:0] spd;
    logic [31:0] rl;
    logic [31:0] rr;
    seg = 0;
    spd = '0;
    rl = $urandom_range(2000);
    rr = $urandom_range(2000);
    for (int i = 0; i < n_ticks; i++) begin
      if (seg == 0) begin
        seg = $urandom_range(1, 30);
        case ($urandom_range(9))
          0: spd = 16'h8000;
          1: spd = 16'h7fff;
          2: spd = 16'($urandom);
          3: spd = '0;
          default: spd = 16'($urandom_range(16000) - 8000);
        endcase
      end
      seg--;
      rl = rl + $urandom_range(120) - 60;
      rr = rr + $urandom_range(120) - 60;
      push_cmd(spd, ($urandom_range(9) == 0) ? 32'($urandom) : rl,
               ($urandom_range(9) == 0) ? 32'($urandom) : rr,
               $urandom_range(99) < 12, $urandom_range(99) < 12);
    end
  endtask

  initial begin
    cfg_t defaults;
    defaults = '{MAX_SETPOINT_RST, STEP_RST, SOFT_ZONE_RST,
                 GAIN_SOFT_RST, GAIN_NORMAL_RST, DEAD_ZONE_RST};
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Directed ticks at the reset settings.
    push_cmd(16'h0000, 32'd0, 32'd0, 1'b0, 1'b0);
    push_cmd(16'h8000, 32'd0, 32'd0, 1'b0, 1'b0);
    push_cmd(16'h7fff, 32'h7fffffff, 32'h80000000, 1'b0, 1'b0);
    push_cmd(16'h0001, 32'hffffffff, 32'hffffffff, 1'b0, 1'b0);
    push_cmd(16'hffff, 32'd5, -32'sd5, 1'b1, 1'b1);
    push_cmd(16'h0000, 32'd1000, 32'd1000, 1'b1, 1'b1);
    push_cmd(16'h0000, 32'd1000, 32'd1000, 1'b0, 1'b0);
    push_cmd(16'h0000, 32'd1300, 32'd1300, 1'b0, 1'b0);
    push_cmd(16'h0000, 32'd1300, 32'd1300, 1'b0, 1'b0);
    push_cmd(16'h0000, 32'd1300, 32'd1000, 1'b0, 1'b0);
    push_cmd(16'h0000, 32'd1300, 32'd1000, 1'b0, 1'b0);
    push_cmd(16'h0000, 32'd1000, 32'd1300, 1'b0, 1'b0);
    push_cmd(16'h0000, 32'd1000, 32'd1300, 1'b0, 1'b0);
    push_cmd(16'h0000, 32'd1005, 32'd1005, 1'b1, 1'b1);
    push_cmd(16'h0000, 32'd900, 32'd900, 1'b1, 1'b1);
    push_cmd(16'h8000, 32'h80000000, 32'h7fffffff, 1'b1, 1'b1);
    push_cmd(16'h7fff, 32'h55555555, 32'haaaaaaaa, 1'b0, 1'b1);
    push_cmd(16'h5555, 32'haaaaaaaa, 32'h55555555, 1'b1, 1'b0);
    push_cmd(16'haaaa, 32'd1400, 32'd1400, 1'b1, 1'b1);
    push_cmd(16'h0000, 32'd1400, 32'd1400, 1'b0, 1'b0);

    apply_settings('{16'hffff, 8'hff, 16'hffff, 16'hffff, 16'hffff, 10'h3ff});
    random_phase(200);
    apply_settings('0);
    random_phase(200);
    apply_settings('{16'd3, 8'hff, SOFT_ZONE_RST, GAIN_SOFT_RST, GAIN_NORMAL_RST, 10'd0});
    random_phase(150);
    for (int p = 0; p < 5; p++) begin
      apply_settings(random_settings());
      if (p == 1) begin
        write_reg(SPARE_ADDR_A, $urandom);
        write_reg(SPARE_ADDR_B, $urandom);
      end
      calm = (p == 2);
      random_phase(180);
      if (p == 2) begin
        wait_idle();
        calm = 1'b0;
      end
    end

    // Steady descent at full step, then both limit switches land the lift.
    apply_settings('{MAX_SETPOINT_RST, 8'hff, SOFT_ZONE_RST, GAIN_SOFT_RST,
                     GAIN_NORMAL_RST, DEAD_ZONE_RST});
    for (int i = 0; i < 80; i++)
      push_cmd(16'h7fff, $urandom_range(3000), $urandom_range(3000), 1'b0, 1'b0);
    push_cmd(16'h0000, 32'd700, 32'd700, 1'b1, 1'b1);

    apply_settings(defaults);
    random_phase(200);

    wait_idle();
    repeat (10) @(posedge clk);
    $display("Checked %0d result beats from %0d input beats over %0d register settings.",
             n_out, n_in, n_settings + 1);
    $display("The lift homed %0d times and the soft gain was chosen on %0d ticks.",
             n_home, n_soft);
    if (n_err == 0 && result_q.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #100000;
    $display("Timeout after %0d input and %0d result beats.", n_in, n_out);
    $display("Mismatches found");
    $finish;
  end

endmodule
